[rtl/mrcm_pkg.sv]
// shared constants and types for the matrix row/column mean and matrix-vector block
package mrcm_pkg;

   localparam int MAX_COLS = 16;
   localparam int MAX_ROWS = 256;

   localparam int ELEM_W     = 16;
   localparam int PROD_W     = 2 * ELEM_W;
   localparam int ROW_SUM_W  = 22;
   localparam int COL_SUM_W  = 24;
   localparam int DOT_W      = 37;
   localparam int ROW_CNT_W  = 9;
   localparam int COL_CNT_W  = 5;
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_W      = 8;
   localparam int IDX_W      = 8;
   localparam int DIV_W      = ROW_CNT_W;
   localparam int DIV_STEP_W = $clog2(COL_SUM_W);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = ROW_CNT_W;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 2'd1;

   localparam logic KIND_ROW = 1'b0;
   localparam logic KIND_COL = 1'b1;

   typedef struct packed {
      logic                        kind;
      logic [IDX_W-1:0]            index;
      logic signed [COL_SUM_W-1:0] sum;
      logic [DIV_W-1:0]            divisor;
      logic signed [DOT_W-1:0]     dot;
      logic                        last;
   } job_type;

endpackage

[rtl/matrix_row_col_mean_matvec.sv]
// top level: streaming matrix-vector multiply with row and column means
// The block takes one matrix element at a time (accept, then multiply-accumulate in the
// front end) while the queue has room, and takes the next only after that step. At the end
// of each row a row job enters a four-entry queue; after the last element the front end
// holds req_stall high while it moves the column sums into the queue, one per cycle
// whenever the queue has room, and clears them. The back end turns each job into one result
// with a bit-serial divider (pop, 24 quotient bits, output load) and pops the next job only
// after the result is loaded, so the queue absorbs the bursts; with short rows and at the
// column sweep the divider sets the sustained element rate. A configuration write restarts
// the matrix and is meant to be issued only while the block is idle.
module matrix_row_col_mean_matvec import mrcm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_element,
   input  logic signed [ELEM_W-1:0] req_vector_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_result_kind,
   output logic [IDX_W-1:0]         rsp_result_index,
   output logic signed [ELEM_W-1:0] rsp_mean_value,
   output logic signed [DOT_W-1:0]  rsp_dot_product,
   output logic                     rsp_last,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   logic    push;
   job_type push_job;
   logic    fifo_full;
   logic    pop;
   job_type pop_job;
   logic    fifo_empty;

   mrcm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_element      (req_element),
      .req_vector_value (req_vector_value),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .push             (push),
      .push_job         (push_job),
      .fifo_full        (fifo_full)
   );

   mrcm_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (fifo_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (fifo_empty)
   );

   mrcm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_job          (pop_job),
      .fifo_empty       (fifo_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_result_index (rsp_result_index),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_dot_product  (rsp_dot_product),
      .rsp_last         (rsp_last)
   );

endmodule

[rtl/mrcm_fifo.sv]
// small job queue between the element front end and the divider back end
module mrcm_fifo import mrcm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   job_type                 entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_PTR_W:0]     count_ff;
   logic [FIFO_PTR_W:0]     count_in;

   assign full    = (count_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (FIFO_PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (FIFO_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/mrcm_front.sv]
// front end: configuration, element accept, multiply-accumulate and column sweep
module mrcm_front import mrcm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_element,
   input  logic signed [ELEM_W-1:0] req_vector_value,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   output logic                     push,
   output job_type                  push_job,
   input  logic                     fifo_full
);

   typedef enum logic [2:0] {
      F_IDLE  = 3'b001,
      F_ACC   = 3'b010,
      F_SWEEP = 3'b100
   } front_state_type;

   front_state_type             state_ff;
   logic [ROW_CNT_W-1:0]        row_count_ff;
   logic [COL_CNT_W-1:0]        col_count_ff;
   logic [ROW_CNT_W-1:0]        rows_eff;
   logic [COL_CNT_W-1:0]        cols_eff;
   logic [COL_W-1:0]            col_pos_ff;
   logic [ROW_W-1:0]            row_pos_ff;
   logic [COL_W-1:0]            sweep_ff;
   logic signed [ROW_SUM_W-1:0] row_sum_ff;
   logic signed [DOT_W-1:0]     dot_ff;
   logic signed [COL_SUM_W-1:0] col_sums_ff [MAX_COLS];

   logic signed [ELEM_W-1:0]    elem_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic [COL_W-1:0]            col_ff;
   logic [ROW_W-1:0]            row_idx_ff;
   logic                        row_end_ff;
   logic                        mat_end_ff;

   logic                        accept;
   logic                        restart;
   logic                        row_end;
   logic                        mat_end;
   logic                        sweep_last;
   logic [COL_W-1:0]            rd_idx;
   logic signed [COL_SUM_W-1:0] col_rd;
   logic signed [ROW_SUM_W-1:0] row_sum_in;
   logic signed [DOT_W-1:0]     dot_in;
   logic signed [COL_SUM_W-1:0] col_sum_in;

   always_comb begin
      if (row_count_ff == '0) begin
         rows_eff = ROW_CNT_W'(1);
      end else if (row_count_ff > ROW_CNT_W'(MAX_ROWS)) begin
         rows_eff = ROW_CNT_W'(MAX_ROWS);
      end else begin
         rows_eff = row_count_ff;
      end
      if (col_count_ff == '0) begin
         cols_eff = COL_CNT_W'(1);
      end else if (col_count_ff > COL_CNT_W'(MAX_COLS)) begin
         cols_eff = COL_CNT_W'(MAX_COLS);
      end else begin
         cols_eff = col_count_ff;
      end
   end

   assign req_stall  = (state_ff != F_IDLE) || fifo_full;
   assign accept     = req_valid && !req_stall;
   assign restart    = csr_wr_en && ((csr_index == CSR_ROW_COUNT) ||
                                     (csr_index == CSR_COL_COUNT));
   assign row_end    = (COL_CNT_W'(col_pos_ff) == cols_eff - COL_CNT_W'(1));
   assign mat_end    = row_end && (ROW_CNT_W'(row_pos_ff) == rows_eff - ROW_CNT_W'(1));
   assign sweep_last = (COL_CNT_W'(sweep_ff) == cols_eff - COL_CNT_W'(1));

   assign rd_idx     = (state_ff == F_SWEEP) ? sweep_ff : col_ff;
   assign col_rd     = col_sums_ff[rd_idx];
   assign row_sum_in = row_sum_ff + {{(ROW_SUM_W-ELEM_W){elem_ff[ELEM_W-1]}}, elem_ff};
   assign dot_in     = dot_ff + {{(DOT_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign col_sum_in = col_rd + {{(COL_SUM_W-ELEM_W){elem_ff[ELEM_W-1]}}, elem_ff};

   always_comb begin
      push     = 1'b0;
      push_job = '0;
      if ((state_ff == F_ACC) && row_end_ff) begin
         push             = 1'b1;
         push_job.kind    = KIND_ROW;
         push_job.index   = row_idx_ff;
         push_job.sum     = {{(COL_SUM_W-ROW_SUM_W){row_sum_in[ROW_SUM_W-1]}}, row_sum_in};
         push_job.divisor = DIV_W'(cols_eff);
         push_job.dot     = dot_in;
         push_job.last    = 1'b0;
      end else if ((state_ff == F_SWEEP) && !fifo_full) begin
         push             = 1'b1;
         push_job.kind    = KIND_COL;
         push_job.index   = IDX_W'(sweep_ff);
         push_job.sum     = col_rd;
         push_job.divisor = rows_eff;
         push_job.dot     = '0;
         push_job.last    = sweep_last;
      end
   end

   // transaction payload for the accumulate cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         elem_ff    <= req_element;
         prod_ff    <= req_element * req_vector_value;
         col_ff     <= col_pos_ff;
         row_idx_ff <= row_pos_ff;
         row_end_ff <= row_end;
         mat_end_ff <= mat_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         row_count_ff <= ROW_CNT_W'(1);
         col_count_ff <= COL_CNT_W'(1);
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         sweep_ff     <= '0;
         row_sum_ff   <= '0;
         dot_ff       <= '0;
         for (int i = 0; i < MAX_COLS; i++) begin
            col_sums_ff[i] <= '0;
         end
      end else if (restart) begin
         if (csr_index == CSR_ROW_COUNT) begin
            row_count_ff <= csr_wdata;
         end else begin
            col_count_ff <= csr_wdata[COL_CNT_W-1:0];
         end
         state_ff   <= F_IDLE;
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         sweep_ff   <= '0;
         row_sum_ff <= '0;
         dot_ff     <= '0;
         for (int i = 0; i < MAX_COLS; i++) begin
            col_sums_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  state_ff <= F_ACC;
                  if (row_end) begin
                     col_pos_ff <= '0;
                     row_pos_ff <= mat_end ? '0 : row_pos_ff + ROW_W'(1);
                  end else begin
                     col_pos_ff <= col_pos_ff + COL_W'(1);
                  end
               end
            end
            F_ACC: begin
               col_sums_ff[col_ff] <= col_sum_in;
               if (row_end_ff) begin
                  row_sum_ff <= '0;
                  dot_ff     <= '0;
               end else begin
                  row_sum_ff <= row_sum_in;
                  dot_ff     <= dot_in;
               end
               sweep_ff <= '0;
               state_ff <= mat_end_ff ? F_SWEEP : F_IDLE;
            end
            F_SWEEP: begin
               if (!fifo_full) begin
                  col_sums_ff[sweep_ff] <= '0;
                  sweep_ff              <= sweep_ff + COL_W'(1);
                  if (sweep_last) begin
                     state_ff <= F_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

endmodule

[rtl/mrcm_back.sv]
// back end: bit-serial mean divider and result output register
module mrcm_back import mrcm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  job_type                     pop_job,
   input  logic                        fifo_empty,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_result_kind,
   output logic [IDX_W-1:0]            rsp_result_index,
   output logic signed [ELEM_W-1:0]    rsp_mean_value,
   output logic signed [DOT_W-1:0]     rsp_dot_product,
   output logic                        rsp_last
);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_DIV  = 3'b010,
      B_DONE = 3'b100
   } back_state_type;

   back_state_type              state_ff;
   job_type                     job_ff;
   logic                        neg_ff;
   logic [COL_SUM_W-1:0]        quo_ff;
   logic [DIV_W-1:0]            rem_ff;
   logic [DIV_STEP_W-1:0]       step_ff;

   logic                        rsp_valid_ff;
   logic                        kind_ff;
   logic [IDX_W-1:0]            index_ff;
   logic signed [ELEM_W-1:0]    mean_ff;
   logic signed [DOT_W-1:0]     dot_ff;
   logic                        last_ff;

   logic [DIV_W:0]              rem_sh;
   logic [DIV_W:0]              rem_diff;
   logic                        q_bit;
   logic [COL_SUM_W-1:0]        mag;
   logic [COL_SUM_W-1:0]        q_signed;
   logic                        out_free;
   logic                        load_out;

   assign pop      = (state_ff == B_IDLE) && !fifo_empty;
   assign mag      = pop_job.sum[COL_SUM_W-1] ? (~pop_job.sum + COL_SUM_W'(1))
                                              : pop_job.sum;
   assign rem_sh   = {rem_ff, quo_ff[COL_SUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, job_ff.divisor};
   assign q_bit    = (rem_sh >= {1'b0, job_ff.divisor});
   assign q_signed = neg_ff ? (~quo_ff + COL_SUM_W'(1)) : quo_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_out = (state_ff == B_DONE) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         step_ff  <= '0;
      end else begin
         case (state_ff)
            B_IDLE: begin
               if (pop) begin
                  step_ff  <= '0;
                  state_ff <= B_DIV;
               end
            end
            B_DIV: begin
               step_ff <= step_ff + DIV_STEP_W'(1);
               if (step_ff == DIV_STEP_W'(COL_SUM_W - 1)) begin
                  state_ff <= B_DONE;
               end
            end
            B_DONE: begin
               if (out_free) begin
                  state_ff <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   // restoring division on the magnitude, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= pop_job;
         neg_ff <= pop_job.sum[COL_SUM_W-1];
         quo_ff <= mag;
         rem_ff <= '0;
      end else if (state_ff == B_DIV) begin
         rem_ff <= q_bit ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
         quo_ff <= {quo_ff[COL_SUM_W-2:0], q_bit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         kind_ff  <= job_ff.kind;
         index_ff <= job_ff.index;
         mean_ff  <= q_signed[ELEM_W-1:0];
         dot_ff   <= job_ff.dot;
         last_ff  <= job_ff.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_result_index = index_ff;
   assign rsp_mean_value   = mean_ff;
   assign rsp_dot_product  = dot_ff;
   assign rsp_last         = last_ff;

endmodule

[rtl/mrcm_checker.sv]
// port-level checker for the matrix mean block and its bind
module mrcm_checker import mrcm_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic                     rsp_result_kind,
   input logic [IDX_W-1:0]         rsp_result_index,
   input logic signed [ELEM_W-1:0] rsp_mean_value,
   input logic signed [DOT_W-1:0]  rsp_dot_product,
   input logic                     rsp_last
);

   // stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mean_value) &&
         $stable(rsp_result_index) && $stable(rsp_dot_product) && $stable(rsp_last))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_COL) |-> rsp_dot_product == '0)
      else $error("column result with nonzero dot product");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_result_kind == KIND_COL)
      else $error("last flag on a row result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_COL) |-> rsp_result_index < IDX_W'(MAX_COLS))
      else $error("column index out of range");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind matrix_row_col_mean_matvec mrcm_checker u_mrcm_checker (.*);

[dv/matrix_row_col_mean_matvec_checker.sv]
// checker for the matrix row/column mean block: predicts every result and compares transactions
module matrix_row_col_mean_matvec_checker import mrcm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_element,
   input  logic signed [ELEM_W-1:0] req_vector_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic                     rsp_result_kind,
   input  logic [IDX_W-1:0]         rsp_result_index,
   input  logic signed [ELEM_W-1:0] rsp_mean_value,
   input  logic signed [DOT_W-1:0]  rsp_dot_product,
   input  logic                     rsp_last,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   output int                       fail_count,
   output int                       pending,
   output int                       row_results,
   output int                       col_means,
   output int                       matrices_done
);

   typedef struct packed {
      logic                     kind;
      logic [IDX_W-1:0]         index;
      logic signed [ELEM_W-1:0] mean;
      logic signed [DOT_W-1:0]  dot;
      logic                     last;
   } matrix_result_type;

   matrix_result_type awaited_results[$];

   logic [ROW_CNT_W-1:0]        row_count_reg;
   logic [COL_CNT_W-1:0]        col_count_reg;
   logic signed [COL_SUM_W-1:0] col_sum [MAX_COLS];
   logic signed [ROW_SUM_W-1:0] row_acc;
   logic signed [DOT_W-1:0]     dot_acc;
   int                          col_pos;
   int                          row_pos;
   int                          errors = 0;
   int                          n_rows = 0;
   int                          n_cols = 0;
   int                          n_mats = 0;

   function automatic int active_cols();
      if (col_count_reg == 0) return 1;
      if (col_count_reg > MAX_COLS) return MAX_COLS;
      return int'(col_count_reg);
   endfunction

   function automatic int active_rows();
      if (row_count_reg == 0) return 1;
      if (row_count_reg > MAX_ROWS) return MAX_ROWS;
      return int'(row_count_reg);
   endfunction

   task automatic clear_matrix();
      foreach (col_sum[j]) col_sum[j] = '0;
      row_acc = '0;
      dot_acc = '0;
      col_pos = 0;
      row_pos = 0;
   endtask

   task automatic push_result(input logic kind, input logic [IDX_W-1:0] index,
                              input logic signed [ELEM_W-1:0] mean,
                              input logic signed [DOT_W-1:0] dot, input logic last);
      matrix_result_type r;
      r.kind  = kind;
      r.index = index;
      r.mean  = mean;
      r.dot   = dot;
      r.last  = last;
      awaited_results.push_back(r);
   endtask

   // one element in; row result at a row end, column means after the last row
   task automatic accumulate_element(input logic signed [ELEM_W-1:0] e,
                                     input logic signed [ELEM_W-1:0] v);
      int cols;
      int rows;
      int c;
      cols = active_cols();
      rows = active_rows();
      c = (col_pos >= cols) ? cols - 1 : col_pos;
      row_acc = row_acc + e;
      dot_acc = dot_acc + longint'(e) * longint'(v);
      col_sum[c] = col_sum[c] + e;
      if (c + 1 < cols) begin
         col_pos = c + 1;
      end else begin
         push_result(KIND_ROW, IDX_W'(row_pos), ELEM_W'(longint'(row_acc) / cols), dot_acc,
                     1'b0);
         row_acc = '0;
         dot_acc = '0;
         col_pos = 0;
         if (row_pos + 1 < rows) begin
            row_pos++;
         end else begin
            for (int j = 0; j < cols; j++)
               push_result(KIND_COL, IDX_W'(j), ELEM_W'(longint'(col_sum[j]) / rows), '0,
                           j + 1 == cols);
            clear_matrix();
         end
      end
   endtask

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      matrix_result_type head;
      if (reset) begin
         row_count_reg = ROW_CNT_W'(1);
         col_count_reg = COL_CNT_W'(1);
         clear_matrix();
         awaited_results.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_ROW_COUNT) begin
               row_count_reg = csr_wdata[ROW_CNT_W-1:0];
               clear_matrix();
            end else if (csr_index == CSR_COL_COUNT) begin
               col_count_reg = csr_wdata[COL_CNT_W-1:0];
               clear_matrix();
            end
         end
         if (req_valid && !req_stall) accumulate_element(req_element, req_vector_value);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: extra transaction, expected none, actual %0d %0d %0d %0d %0d",
                        $time, rsp_result_kind, rsp_result_index, rsp_mean_value,
                        rsp_dot_product, rsp_last);
               errors++;
            end else begin
               head = awaited_results.pop_front();
               check_field("result_kind", longint'(head.kind), longint'(rsp_result_kind));
               check_field("result_index", longint'(head.index), longint'(rsp_result_index));
               check_field("mean_value", longint'(head.mean), longint'(rsp_mean_value));
               check_field("dot_product", longint'(head.dot), longint'(rsp_dot_product));
               check_field("last", longint'(head.last), longint'(rsp_last));
            end
            if (rsp_result_kind == KIND_ROW) n_rows++;
            else n_cols++;
            if (rsp_last) n_mats++;
         end
      end
      fail_count    <= errors;
      pending       <= awaited_results.size();
      row_results   <= n_rows;
      col_means     <= n_cols;
      matrices_done <= n_mats;
   end

endmodule

[dv/matrix_row_col_mean_matvec_tb.sv]
// testbench top: clock, reset, stimulus and verdict for the matrix row/column mean block
module matrix_row_col_mean_matvec_tb;
   import mrcm_pkg::*;

   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 80;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   localparam logic signed [ELEM_W-1:0] Q_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
   localparam logic signed [ELEM_W-1:0] Q_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

   typedef enum int {FILL_RANDOM, FILL_MIN, FILL_MAX, FILL_EDGES} fill_kind_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [ELEM_W-1:0] req_element = '0;
   logic signed [ELEM_W-1:0] req_vector_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_result_kind;
   logic [IDX_W-1:0]         rsp_result_index;
   logic signed [ELEM_W-1:0] rsp_mean_value;
   logic signed [DOT_W-1:0]  rsp_dot_product;
   logic                     rsp_last;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   int fail_count;
   int pending;
   int row_results;
   int col_means;
   int matrices_done;

   logic quiet_stretch = 1'b0;
   int   eff_rows = 1;
   int   eff_cols = 1;
   int   elements_sent = 0;
   int   settings_used = 1;
   int   random_items = 0;
   int   idle_cycles = 0;

   matrix_row_col_mean_matvec dut (.*);

   matrix_row_col_mean_matvec_checker mean_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !quiet_stretch && ($urandom_range(99) < 6);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
         $display("matrix_row_col_mean_matvec_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [ELEM_W-1:0] pick_value(input fill_kind_type fill);
      case (fill)
         FILL_MIN:   return Q_MIN;
         FILL_MAX:   return Q_MAX;
         FILL_EDGES: return $urandom_range(1) ? Q_MIN : Q_MAX;
         default:    return ELEM_W'($urandom);
      endcase
   endfunction

   function automatic fill_kind_type pick_fill();
      case ($urandom_range(9))
         0:       return FILL_MIN;
         1:       return FILL_MAX;
         2:       return FILL_EDGES;
         default: return FILL_RANDOM;
      endcase
   endfunction

   task automatic send_pair(input logic signed [ELEM_W-1:0] e,
                            input logic signed [ELEM_W-1:0] v);
      if (!quiet_stretch && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_element      <= e;
      req_vector_value <= v;
      do @(posedge clock); while (req_stall);
      elements_sent++;
   endtask

   task automatic send_elements(input int count, input fill_kind_type fill);
      for (int i = 0; i < count; i++)
         send_pair(pick_value(fill), pick_value(fill == FILL_RANDOM ? FILL_RANDOM : FILL_EDGES));
   endtask

   // hold the sender until every predicted result is back, then let the front end settle
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int rows_val, input int cols_val);
      logic [CSR_DATA_W-1:0] col_data;
      drain_results();
      col_data = CSR_DATA_W'($urandom);
      col_data[COL_CNT_W-1:0] = cols_val[COL_CNT_W-1:0];
      if ($urandom_range(1) == 0) write_csr(CSR_COL_COUNT, col_data);
      write_csr(CSR_ROW_COUNT, CSR_DATA_W'(rows_val));
      write_csr(CSR_COL_COUNT, col_data);
      eff_rows = (rows_val == 0) ? 1 : (rows_val > MAX_ROWS) ? MAX_ROWS : rows_val;
      eff_cols = (cols_val == 0) ? 1 : (cols_val > MAX_COLS) ? MAX_COLS : cols_val;
      settings_used++;
   endtask

   initial begin
      int rows_val;
      int cols_val;
      int mats;
      int partial;
      int phase;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting, one by one: every element closes a matrix
      send_pair(Q_MAX, Q_MAX);
      send_pair(Q_MIN, Q_MIN);
      send_pair(Q_MIN, Q_MAX);
      send_pair('0, '0);
      send_pair('1, '1);

      // zero counts act as one
      configure(0, 0);
      send_elements(2, FILL_EDGES);

      // unused register index mid-matrix must not restart it
      configure(2, 3);
      send_elements(4, FILL_MAX);
      drain_results();
      write_csr(CSR_SPARE_LO, CSR_DATA_W'($urandom));
      send_elements(2, FILL_MAX);

      // register write mid-matrix restarts it
      send_elements(2, FILL_MIN);
      drain_results();
      write_csr(CSR_COL_COUNT, CSR_DATA_W'(3));
      send_elements(6, FILL_MIN);

      // counts above the maximum; a few rows show the row count is not cut short
      configure($urandom_range(MAX_ROWS + 1, 511), 1);
      send_elements(4, FILL_MIN);
      configure(2, $urandom_range(MAX_COLS, 31));
      send_elements(eff_rows * eff_cols, FILL_EDGES);
      configure(1, MAX_COLS);
      send_elements(eff_rows * eff_cols, FILL_MAX);

      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         quiet_stretch <= (phase < 2);
         case ($urandom_range(9))
            0:       rows_val = 0;
            1:       rows_val = $urandom_range(7, 12);
            default: rows_val = $urandom_range(1, 4);
         endcase
         case ($urandom_range(9))
            0:       cols_val = 0;
            1:       cols_val = $urandom_range(MAX_COLS, 31);
            default: cols_val = $urandom_range(1, 8);
         endcase
         configure(rows_val, cols_val);
         mats = $urandom_range(1, 3);
         for (int m = 0; m < mats && random_items < RANDOM_ITEMS; m++) begin
            if (m > 0 && $urandom_range(3) == 0) begin
               drain_results();
               if ($urandom_range(1)) write_csr(CSR_SPARE_HI, CSR_DATA_W'($urandom));
            end
            send_elements(eff_rows * eff_cols, pick_fill());
            random_items += eff_rows * eff_cols;
         end
         // broken matrix, cut short by the next register write
         if ($urandom_range(4) == 0 && eff_rows * eff_cols > 1) begin
            partial = $urandom_range(1, eff_rows * eff_cols - 1);
            send_elements(partial, FILL_RANDOM);
            random_items += partial;
         end
         phase++;
      end
      quiet_stretch <= 1'b0;

      drain_results();
      $display("run covered %0d elements over %0d register settings", elements_sent,
               settings_used);
      $display("checked %0d row results and %0d column means from %0d complete matrices",
               row_results, col_means, matrices_done);
      if (fail_count == 0) begin
         $display("matrix_row_col_mean_matvec_tb: PASS");
      end else begin
         $display("matrix_row_col_mean_matvec_tb: FAIL");
      end
      $finish;
   end

endmodule
